FILE: rtl/core/dqvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqvs_pkg: shared definitions for the deque with value search
// Operation and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package dqvs_pkg;

   // parameter defaults
   localparam int DEPTH_DEFAULT       = 256;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // field widths of the beats
   localparam int FUNC_W      = 3;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int POSITION_W  = 8;
   localparam int OCCUPANCY_W = 9;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 56;

   // operation codes
   localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] OP_FIND       = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage : dqvs_pkg
`default_nettype wire

FILE: rtl/core/deque_with_value_search_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deque_with_value_search_core: bounded double-ended queue with value search
// Circular store with front pointer and count, a sequencer around one
// slot-address adder, one store write port, one store read port and one equality comparator.
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat per operation, tuser carries the operation code
//   (push front, push back, pop front, pop back, search), tdata the value
//   rsp channel: exactly one beat per request, in request order, carrying the
//   removed value, status, search outcome, occupancy and empty flag
// timing
//   a request is taken only while the sequencer is idle; pushes, pops and
//   unused codes pass through the execute and finish states to the response
//   register; a search also scans between the two, comparing no entries when
//   empty, else 1 .. occupancy; the scan reads one store entry per
//   cycle through the single registered read port and compares it against
//   the search value
// reset
//   synchronous, active high: queue becomes empty, front pointer goes to zero
//   and no response is pending; store contents are not cleared
// back-pressure
//   the response waits in an output register while rsp_tready is low; the
//   next request may be taken and worked on meanwhile, and its result waits
//   in the sequencer until the output register is free
// ----------------------------------------------------------------------------
module deque_with_value_search_core
   import dqvs_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [31:0] value
   input  wire logic [FUNC_W-1:0]     req_tuser,  // [2:0] func
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [31:0] removed_value, [33:32] status, [34] found, [42:35] position,
   // [51:43] occupancy, [52] is_empty, [55:53] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int AW = $clog2(DEPTH);      // store index width
   localparam int CW = $clog2(DEPTH + 1);  // count width, holds DEPTH itself

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_FINISH
   } state_type;

   // sequencer and queue state
   state_type               state_ff, state_in;
   logic [FUNC_W-1:0]       op_ff, op_in;
   logic [VALUE_WIDTH-1:0]  val_ff, val_in;
   logic [AW-1:0]           front_ff, front_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           ck_ff, ck_in;       // index of the entry being compared
   logic [STATUS_W-1:0]     stat_ff, stat_in;
   logic                    found_ff, found_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]      rsp_removed_ff, rsp_removed_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POSITION_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [OCCUPANCY_W-1:0]  rsp_occ_ff, rsp_occ_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   // store
   logic [VALUE_WIDTH-1:0]  mem [DEPTH];
   logic [VALUE_WIDTH-1:0]  rd_data_ff;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;

   // shared slot adder: slot = (front + k) mod depth, k <= depth
   logic [CW-1:0]           k_sel;
   logic [CW:0]             slot_sum;
   logic [AW-1:0]           slot;
   logic [AW-1:0]           front_dec;
   logic                    is_full;
   logic                    is_pop;
   logic [CW-1:0]           ck_next;

   always_comb begin
      slot_sum = (CW+1)'(front_ff) + (CW+1)'(k_sel);
      if (slot_sum >= (CW+1)'(DEPTH)) begin
         slot_sum = slot_sum - (CW+1)'(DEPTH);
      end
      slot = slot_sum[AW-1:0];
   end

   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - 1'b1;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_pop    = (op_ff == OP_POP_FRONT) || (op_ff == OP_POP_BACK);
   assign ck_next   = ck_ff + 1'b1;

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      val_in         = val_ff;
      front_in       = front_ff;
      count_in       = count_ff;
      ck_in          = ck_ff;
      stat_in        = stat_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_empty_in   = rsp_empty_ff;
      k_sel          = '0;
      wr_en          = 1'b0;
      wr_addr        = slot;
      rd_en          = 1'b0;
      rd_addr        = slot;

      // response taken downstream
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               val_in   = VALUE_WIDTH'(req_tdata[VALUE_W-1:0]);
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            stat_in  = ST_OK;
            found_in = 1'b0;
            ck_in    = '0;
            state_in = S_FINISH;
            case (op_ff)
               OP_PUSH_FRONT: begin
                  if (is_full) begin
                     stat_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = front_dec;
                     front_in = front_dec;
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_PUSH_BACK: begin
                  k_sel = count_ff;
                  if (is_full) begin
                     stat_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_POP_FRONT: begin
                  k_sel = CW'(1);
                  if (count_ff == '0) begin
                     stat_in = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = front_ff;
                     count_in = count_ff - 1'b1;
                     // last entry gone: pointer back home
                     front_in = (count_ff == CW'(1)) ? '0 : slot;
                  end
               end
               OP_POP_BACK: begin
                  k_sel = count_ff - 1'b1;
                  if (count_ff == '0) begin
                     stat_in = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     count_in = count_ff - 1'b1;
                     if (count_ff == CW'(1)) begin
                        front_in = '0;
                     end
                  end
               end
               OP_FIND: begin
                  k_sel = '0;
                  if (count_ff != '0) begin
                     rd_en    = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  stat_in = ST_OK;
               end
            endcase
         end

         S_SCAN: begin
            // rd_data_ff holds entry ck; fetch entry ck+1 in the same cycle
            k_sel = ck_next;
            if (rd_data_ff == val_ff) begin
               found_in = 1'b1;
               state_in = S_FINISH;
            end else if (ck_next == count_ff) begin
               state_in = S_FINISH;
            end else begin
               ck_in = ck_next;
               rd_en = 1'b1;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_removed_in = (is_pop && stat_ff == ST_OK) ?
                                VALUE_W'(rd_data_ff) : '0;
               rsp_status_in  = stat_ff;
               rsp_found_in   = found_ff;
               rsp_pos_in     = found_ff ? POSITION_W'(ck_ff) : '0;
               rsp_occ_in     = OCCUPANCY_W'(count_ff);
               rsp_empty_in   = (count_ff == '0);
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      val_ff         <= val_in;
      ck_ff          <= ck_in;
      stat_ff        <= stat_in;
      found_ff       <= found_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   // store, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= val_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_empty_ff, rsp_occ_ff, rsp_pos_ff,
                        rsp_found_ff, rsp_status_ff, rsp_removed_ff};

   // an accepted beat always starts execution next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EXEC))
      else $error("accepted request did not enter execution");

   // a push into a non-full queue grows it by one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && (op_ff == OP_PUSH_FRONT || op_ff == OP_PUSH_BACK)
       && !is_full) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not increment occupancy");

   // an empty queue always has its front pointer at zero
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (front_ff == '0))
      else $error("front pointer off home while empty");

   // occupancy never exceeds the store depth
   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(DEPTH)))
      else $error("occupancy above depth");

endmodule : deque_with_value_search_core
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for deque_with_value_search_core
// Drives push, pop, search and unused operation beats with random gaps and
// back-pressure. A mirror of the deque predicts every response beat and
// compares it field by field, in order.
// ----------------------------------------------------------------------------
module tb;
   import dqvs_pkg::*;

   localparam int SLOTS          = DEPTH_DEFAULT;
   localparam int TOTAL_ITEMS    = 1950;
   localparam int STALL_LIMIT    = 5000;   // longest search plus the long hold-off, many times over
   localparam int HOLD_OFF       = 400;    // receiver hold-off, cycles
   localparam int DRAIN_CYCLES   = 50;
   localparam int CALM_FIRST     = 700;    // stretch of beats with no idling on either side
   localparam int CALM_LAST      = 1000;
   localparam logic [FUNC_W-1:0] OP_UNUSED_LO  = 3'd5;
   localparam logic [FUNC_W-1:0] OP_UNUSED_MID = 3'd6;
   localparam logic [FUNC_W-1:0] OP_UNUSED_HI  = 3'd7;

   // response beat as packed in rsp_tdata, top bits first
   typedef struct packed {
      logic [2:0]             pad;
      logic                   is_empty;
      logic [OCCUPANCY_W-1:0] occupancy;
      logic [POSITION_W-1:0]  position;
      logic                   found;
      logic [STATUS_W-1:0]    status;
      logic [VALUE_W-1:0]     removed_value;
   } deque_answer_type;

   // -------------------------------------------------------------------------
   // mirror of the deque: predicts one response per accepted request beat
   // -------------------------------------------------------------------------
   class deque_mirror;
      logic [VALUE_W-1:0]     slots [SLOTS];
      int                     head;
      int                     held;
      deque_answer_type       owed_answers [$];
      int                     failures;
      int                     reported;

      function new();
         head      = 0;
         held      = 0;
         failures  = 0;
         reported  = 0;
      endfunction

      // work out the response for an accepted request and queue it
      function void note_request(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value);
         deque_answer_type ans;
         ans = '0;
         ans.status = ST_OK;
         case (func)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (held >= SLOTS) begin
                  ans.status = ST_FULL;
               end else if (func == OP_PUSH_FRONT) begin
                  head = (head == 0) ? SLOTS - 1 : head - 1;
                  slots[head] = value;
                  held++;
               end else begin
                  slots[(head + held) % SLOTS] = value;
                  held++;
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (held == 0) begin
                  ans.status = ST_EMPTY;
               end else if (func == OP_POP_FRONT) begin
                  ans.removed_value = slots[head];
                  head = (head + 1) % SLOTS;
                  held--;
               end else begin
                  ans.removed_value = slots[(head + held - 1) % SLOTS];
                  held--;
               end
               if (held == 0) head = 0;
            end
            OP_FIND: begin
               for (int k = 0; k < held; k++) begin
                  if (slots[(head + k) % SLOTS] == value) begin
                     ans.found    = 1'b1;
                     ans.position = k[POSITION_W-1:0];
                     break;
                  end
               end
            end
            default: ;   // unused codes change nothing
         endcase
         ans.occupancy = held[OCCUPANCY_W-1:0];
         ans.is_empty  = (held == 0);
         owed_answers.push_back(ans);
      endfunction

      function void flag(string what, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
         failures++;
         if (reported < 10) begin
            reported++;
            $display("MISMATCH %s: expected %h, got %h", what, want, got);
         end
      endfunction

      // compare a response beat with the oldest prediction
      function void check_answer(logic [RSP_DATA_W-1:0] data);
         deque_answer_type got;
         deque_answer_type want;
         got = deque_answer_type'(data);
         if (owed_answers.size() == 0) begin
            flag("unexpected response beat", '0, data[VALUE_W-1:0]);
            return;
         end
         want = owed_answers.pop_front();
         if (got.removed_value !== want.removed_value)
            flag("removed_value", want.removed_value, got.removed_value);
         if (got.status !== want.status)
            flag("status", VALUE_W'(want.status), VALUE_W'(got.status));
         if (got.found !== want.found)
            flag("found", VALUE_W'(want.found), VALUE_W'(got.found));
         if (got.position !== want.position)
            flag("position", VALUE_W'(want.position), VALUE_W'(got.position));
         if (got.occupancy !== want.occupancy)
            flag("occupancy", VALUE_W'(want.occupancy), VALUE_W'(got.occupancy));
         if (got.is_empty !== want.is_empty)
            flag("is_empty", VALUE_W'(want.is_empty), VALUE_W'(got.is_empty));
      endfunction

      function int waiting();
         return owed_answers.size();
      endfunction

      // some value now held, so searches can hit
      function logic [VALUE_W-1:0] any_held();
         return slots[(head + $urandom_range(0, held - 1)) % SLOTS];
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block
   // -------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [31:0] value
   logic [FUNC_W-1:0]     req_tuser  = '0;   // [2:0] func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [31:0] removed_value, [33:32] status, [34] found, [42:35] position,
   // [51:43] occupancy, [52] is_empty, [55:53] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   deque_mirror book = new();
   bit          calm = 1'b0;    // no idling on either side while set
   int          answers_seen = 0;
   int          quiet_cycles = 0;

   always #10 clock = ~clock;

   deque_with_value_search_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------
   // offer one beat from the next falling edge, with random idle cycles first;
   // returns right after the rising edge that accepts it
   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      book.note_request(func, value);
   endtask

   // a small pool so duplicates pile up, extremes, or wide random values, each about a third of picks
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3, 4, 5: return VALUE_W'($urandom_range(0, 15));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_search_value();
      if (book.held > 0 && $urandom_range(0, 99) < 60) return book.any_held();
      return pick_value();
   endfunction

   // one beat of an episode that walks the occupancy towards a target
   task automatic send_towards(input int target);
      int                 roll;
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] value;
      roll  = $urandom_range(0, 99);
      value = pick_value();
      if (roll < 12) begin
         func  = OP_FIND;
         value = pick_search_value();
      end else if (roll < 15) begin
         func = FUNC_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else if ((book.held < target) == (roll < 80)) begin
         func = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
         func = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      send_request(func, value);
   endtask

   initial begin
      int target;
      int extras;
      int sent;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty corner cases, extremes, first-match search, drain
      send_request(OP_FIND,       32'h0000_0000);
      send_request(OP_POP_FRONT,  32'hFFFF_FFFF);
      send_request(OP_POP_BACK,   32'h1234_5678);
      send_request(OP_UNUSED_LO,  32'hFFFF_FFFF);
      send_request(OP_UNUSED_MID, 32'h0000_0001);
      send_request(OP_UNUSED_HI,  32'h8000_0000);
      send_request(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      send_request(OP_PUSH_BACK,  32'h8000_0000);
      send_request(OP_PUSH_FRONT, 32'h0000_0000);
      send_request(OP_PUSH_BACK,  32'hFFFF_FFFF);
      send_request(OP_PUSH_BACK,  32'h7FFF_FFFF);
      send_request(OP_FIND,       32'h7FFF_FFFF);   // duplicate: first match wins
      send_request(OP_FIND,       32'hFFFF_FFFF);
      send_request(OP_FIND,       32'h0001_2345);   // miss
      send_request(OP_UNUSED_HI,  32'h7FFF_FFFF);
      send_request(OP_POP_FRONT,  32'h0);
      send_request(OP_POP_BACK,   32'h0);
      send_request(OP_POP_BACK,   32'h0);
      send_request(OP_POP_FRONT,  32'h0);
      send_request(OP_POP_FRONT,  32'h0);           // now empty again
      send_request(OP_POP_BACK,   32'h0);
      send_request(OP_FIND,       32'h0);
      sent = 22;

      // random episodes: head for empty, full or somewhere between, and at
      // the empty and full ends overrun it for 2 to 5 more beats
      while (sent < TOTAL_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       target = 0;
            1:       target = SLOTS;
            default: target = $urandom_range(1, SLOTS - 1);
         endcase
         extras = (target == 0 || target == SLOTS) ? $urandom_range(2, 5) : 0;
         while (sent < TOTAL_ITEMS && (book.held != target || extras > 0)) begin
            calm = (sent >= CALM_FIRST && sent < CALM_LAST);
            if (book.held == target) begin
               // overrun the end: push when full, pop when empty, or search it
               extras--;
               case ($urandom_range(0, 2))
                  0: send_request(target == 0 ? OP_POP_FRONT : OP_PUSH_FRONT, pick_value());
                  1: send_request(target == 0 ? OP_POP_BACK : OP_PUSH_BACK, pick_value());
                  default: send_request(OP_FIND, pick_search_value());
               endcase
            end else begin
               send_towards(target);
            end
            sent++;
         end
      end
      calm = 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b0;

      // wait for every owed response, then keep watching for stray response beats
      while (book.waiting() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.failures == 0 && book.waiting() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // response side
   // -------------------------------------------------------------------------
   initial begin
      bit held_off;
      held_off = 1'b0;
      forever begin
         @(negedge clock);
         // one long hold-off so the block fills up and stalls its input
         if (!held_off && answers_seen >= 150) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 33);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         book.check_answer(rsp_tdata);
         answers_seen++;
      end
   end

   // watchdog: no beat on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule : tb

FILE: filelist.f
rtl/core/dqvs_pkg.sv
rtl/core/deque_with_value_search_core.sv
tb/tb.sv
